FILE: sv/txm_pkg.sv
// Shared constants, types and register codes for the X-layout thruster mixer.
`timescale 1ns / 1ps
`default_nettype none

package txm_pkg;

    // Stick sample format: only the low STICK_BITS bits of each axis are used.
    localparam int STICK_W     = 16;
    localparam int STICK_BITS  = 16;
    localparam int Q15_SHIFT   = STICK_W - STICK_BITS;

    // Configuration register widths and reset values.
    localparam int DEADZONE_W  = 15;
    localparam int NEUTRAL_W   = 11;
    localparam int SPAN_W      = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = DEADZONE_W'(1638);
    localparam logic [NEUTRAL_W-1:0]  NEUTRAL_RESET  = NEUTRAL_W'(1500);
    localparam logic [SPAN_W-1:0]     SPAN_RESET     = SPAN_W'(200);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = 2'd2;

    // Datapath widths.
    localparam int MAG_W      = 16;                   // |axis|, up to 32768
    localparam int SUM_W      = 17;                   // |x+y|, |y-x|, |x|+|y|
    localparam int KSPAN_W    = SPAN_W + MAG_W;       // span * M
    localparam int REM_W      = KSPAN_W + SUM_W;      // span * M * |s|
    localparam int Q_W        = 9;                    // quotient magnitude, below 512
    localparam int Q15_FRAC   = 15;                   // divisor is L * 2^15
    localparam int DEN_SHIFT  = Q15_FRAC + Q_W - 1;   // divisor aligned to quotient MSB
    localparam int DEN_W      = SUM_W + DEN_SHIFT;
    localparam int DIV_BITS_PER_STAGE = 3;
    localparam int OUT_W      = 12;
    localparam int RES_W      = OUT_W + 1;            // signed pulse before clamping

    // Pipeline stages: two front, two multiply, three divide, one output.
    localparam int NUM_STAGES = 8;

    // Geometry of one sample after the front end.
    typedef struct packed {
        logic [MAG_W-1:0] m;
        logic [SUM_W-1:0] s_mag;
        logic [SUM_W-1:0] d_mag;
        logic             s_neg;
        logic             d_neg;
        logic [SUM_W-1:0] l;
        logic             zero;
    } front_t;

    // State of both diagonal divisions.
    typedef struct packed {
        logic [REM_W-1:0] rem_s;
        logic [REM_W-1:0] rem_d;
        logic [DEN_W-1:0] den_sh;
        logic [Q_W-1:0]   q_s;
        logic [Q_W-1:0]   q_d;
        logic             s_neg;
        logic             d_neg;
        logic             zero;
    } div_t;

endpackage

`default_nettype wire

FILE: sv/txm_front.sv
// Front end: Q15 normalization, deadzone, and the X-layout geometry terms.
`timescale 1ns / 1ps
`default_nettype none

module txm_front
    import txm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [1:0]            en,
    input  wire logic [STICK_W-1:0]    stick_x,
    input  wire logic [STICK_W-1:0]    stick_y,
    input  wire logic [DEADZONE_W-1:0] deadzone,
    output front_t                     geo
);

    logic signed [STICK_W-1:0] xq, yq;
    logic [MAG_W-1:0]          ax_raw, ay_raw;
    logic                      x_dead, y_dead;

    logic signed [STICK_W-1:0] x_reg, y_reg;
    logic [MAG_W-1:0]          ax_reg, ay_reg;

    logic signed [SUM_W-1:0]   s_val, d_val;
    front_t                    geo_next, geo_reg;

    // Normalize each axis to Q15 and zero it inside the deadzone.
    always_comb
    begin
        xq     = signed'(stick_x << Q15_SHIFT);
        yq     = signed'(stick_y << Q15_SHIFT);
        ax_raw = xq[STICK_W-1] ? MAG_W'(~xq + 1'b1) : MAG_W'(xq);
        ay_raw = yq[STICK_W-1] ? MAG_W'(~yq + 1'b1) : MAG_W'(yq);
        x_dead = ax_raw <= {1'b0, deadzone};
        y_dead = ay_raw <= {1'b0, deadzone};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg  <= x_dead ? '0 : xq;
            y_reg  <= y_dead ? '0 : yq;
            ax_reg <= x_dead ? '0 : ax_raw;
            ay_reg <= y_dead ? '0 : ay_raw;
        end
    end

    // Diagonal terms. |x|+|y| equals max(|x+y|, |y-x|), so it serves as L.
    always_comb
    begin
        s_val            = SUM_W'(x_reg) + SUM_W'(y_reg);
        d_val            = SUM_W'(y_reg) - SUM_W'(x_reg);
        geo_next.m       = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        geo_next.s_neg   = s_val[SUM_W-1];
        geo_next.d_neg   = d_val[SUM_W-1];
        geo_next.s_mag   = s_val[SUM_W-1] ? SUM_W'(~s_val + 1'b1) : SUM_W'(s_val);
        geo_next.d_mag   = d_val[SUM_W-1] ? SUM_W'(~d_val + 1'b1) : SUM_W'(d_val);
        geo_next.l       = SUM_W'(ax_reg) + SUM_W'(ay_reg);
        geo_next.zero    = (ax_reg == '0) && (ay_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            geo_reg <= geo_next;
        end
    end

    assign geo = geo_reg;

endmodule

`default_nettype wire

FILE: sv/txm_mul.sv
// Multiply stages: span times M, then times each diagonal magnitude.
`timescale 1ns / 1ps
`default_nettype none

module txm_mul
    import txm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [1:0]        en,
    input  wire front_t            geo,
    input  wire logic [SPAN_W-1:0] span,
    output div_t                   prod
);

    logic [KSPAN_W-1:0] kspan_reg;
    front_t             geo_reg;
    div_t               prod_next, prod_reg;

    // First product: span scaled by the larger axis magnitude.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            kspan_reg <= KSPAN_W'(span) * KSPAN_W'(geo.m);
            geo_reg   <= geo;
        end
    end

    // Second products form the dividends; the divisor is L * 2^15,
    // aligned to the top quotient bit.
    always_comb
    begin
        prod_next.rem_s  = REM_W'(kspan_reg) * REM_W'(geo_reg.s_mag);
        prod_next.rem_d  = REM_W'(kspan_reg) * REM_W'(geo_reg.d_mag);
        prod_next.den_sh = DEN_W'(geo_reg.l) << DEN_SHIFT;
        prod_next.q_s    = '0;
        prod_next.q_d    = '0;
        prod_next.s_neg  = geo_reg.s_neg;
        prod_next.d_neg  = geo_reg.d_neg;
        prod_next.zero   = geo_reg.zero;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: sv/txm_div.sv
// One restoring-division stage: three quotient bits for both diagonals.
`timescale 1ns / 1ps
`default_nettype none

module txm_div
    import txm_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire div_t cur,
    output div_t      nxt
);

    div_t nxt_next, nxt_reg;

    // Trial-subtract the shifted divisor, one quotient bit per step.
    always_comb
    begin
        nxt_next = cur;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
        begin
            if (REM_W'(nxt_next.den_sh) <= nxt_next.rem_s)
            begin
                nxt_next.rem_s = nxt_next.rem_s - REM_W'(nxt_next.den_sh);
                nxt_next.q_s   = {nxt_next.q_s[Q_W-2:0], 1'b1};
            end
            else
            begin
                nxt_next.q_s   = {nxt_next.q_s[Q_W-2:0], 1'b0};
            end
            if (REM_W'(nxt_next.den_sh) <= nxt_next.rem_d)
            begin
                nxt_next.rem_d = nxt_next.rem_d - REM_W'(nxt_next.den_sh);
                nxt_next.q_d   = {nxt_next.q_d[Q_W-2:0], 1'b1};
            end
            else
            begin
                nxt_next.q_d   = {nxt_next.q_d[Q_W-2:0], 1'b0};
            end
            nxt_next.den_sh = nxt_next.den_sh >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt_reg <= nxt_next;
        end
    end

    assign nxt = nxt_reg;

endmodule

`default_nettype wire

FILE: sv/x_thruster_joystick_mixer.sv
// Top level of the X-layout horizontal thruster mixer.
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+------------------------------------------
//   input   | in_valid / in_stall      | stick_x, stick_y
//   output  | out_valid / out_stall    | front_left_us, front_right_us,
//           |                          | back_left_us, back_right_us
//   config  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; in a stall, input is
// taken until all stages are full. The 8 stages are: two front-end stages,
// two multiply stages, three restoring-divider stages of 3 quotient bits each,
// and the output register. A stage holds while the one after it is full and
// stalled, so empty stages fill in while the output waits. Reset clears all
// valid bits and loads the default register values; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module x_thruster_joystick_mixer
    import txm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [STICK_W-1:0]    stick_x,
    input  wire logic [STICK_W-1:0]    stick_y,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [OUT_W-1:0]           front_left_us,
    output logic [OUT_W-1:0]           front_right_us,
    output logic [OUT_W-1:0]           back_left_us,
    output logic [OUT_W-1:0]           back_right_us,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DEADZONE_W-1:0] deadzone_reg;
    logic [NEUTRAL_W-1:0]  neutral_reg;
    logic [SPAN_W-1:0]     span_reg;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] ready;

    front_t geo;
    div_t   prod, div1, div2, div3;

    logic signed [RES_W-1:0] res_s, res_d;
    logic [OUT_W-1:0]        sum_us_next, diff_us_next;
    logic [OUT_W-1:0]        sum_us_reg, diff_us_reg;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= DEADZONE_RESET;
            neutral_reg  <= NEUTRAL_RESET;
            span_reg     <= SPAN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEADZONE: deadzone_reg <= cfg_data[DEADZONE_W-1:0];
                CFG_NEUTRAL:  neutral_reg  <= cfg_data[NEUTRAL_W-1:0];
                CFG_SPAN:     span_reg     <= cfg_data[SPAN_W-1:0];
                default:      ;
            endcase
        end
    end

    // A stage may load when it is empty or the stage after it moves on.
    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (!ready[k])
            begin
                valid_next[k] = valid_reg[k];
            end
            else if (k == 0)
            begin
                valid_next[k] = in_valid;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // Datapath stages.
    txm_front u_front
    (
        .clk      (clk),
        .en       (ready[1:0]),
        .stick_x  (stick_x),
        .stick_y  (stick_y),
        .deadzone (deadzone_reg),
        .geo      (geo)
    );

    txm_mul u_mul
    (
        .clk  (clk),
        .en   (ready[3:2]),
        .geo  (geo),
        .span (span_reg),
        .prod (prod)
    );

    txm_div u_div1
    (
        .clk (clk),
        .en  (ready[4]),
        .cur (prod),
        .nxt (div1)
    );

    txm_div u_div2
    (
        .clk (clk),
        .en  (ready[5]),
        .cur (div1),
        .nxt (div2)
    );

    txm_div u_div3
    (
        .clk (clk),
        .en  (ready[6]),
        .cur (div2),
        .nxt (div3)
    );

    // Apply the sign, add neutral, and clamp at zero. A centered stick
    // gives neutral on every thruster.
    always_comb
    begin
        res_s = signed'(RES_W'(neutral_reg));
        res_d = signed'(RES_W'(neutral_reg));
        if (!div3.zero)
        begin
            if (div3.s_neg)
                res_s = res_s - signed'(RES_W'(div3.q_s));
            else
                res_s = res_s + signed'(RES_W'(div3.q_s));
            if (div3.d_neg)
                res_d = res_d - signed'(RES_W'(div3.q_d));
            else
                res_d = res_d + signed'(RES_W'(div3.q_d));
        end
        sum_us_next  = res_s[RES_W-1] ? '0 : res_s[OUT_W-1:0];
        diff_us_next = res_d[RES_W-1] ? '0 : res_d[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ready[NUM_STAGES-1])
        begin
            sum_us_reg  <= sum_us_next;
            diff_us_reg <= diff_us_next;
        end
    end

    // Front-left and back-right share the sum diagonal, the others the difference.
    assign front_left_us  = sum_us_reg;
    assign back_right_us  = sum_us_reg;
    assign front_right_us = diff_us_reg;
    assign back_left_us   = diff_us_reg;

    // An accepted item always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[0])
        else $error("accepted item did not enter the first stage");

    // Input backs up only when every stage is full and the output is held.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (valid_reg == '1) && out_stall)
        else $error("input stalled with room in the pipeline");

    // The first divider stage's valid bit holds while that stage is blocked.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ready[4] |=> valid_reg[4])
        else $error("blocked divider stage lost its item");

    // Diagonal pairs always agree.
    a_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (front_left_us == back_right_us) && (front_right_us == back_left_us))
        else $error("diagonal thruster pair mismatch");

endmodule

`default_nettype wire
